### sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// shared types and constants of the positional list block
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CAP_MAX      = 1024;
    localparam int IDX_MAX_W    = $clog2(CAP_MAX);

    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 5;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [IDX_MAX_W-1:0] idx;
        logic [VAL_W-1:0]     new_value;
        logic                 lane_load;
        logic                 lane_shift;
    } cell_cmd_t;

endpackage

### sv/pli_cell.sv
// ----------------------------------------------------------------------------
// pli_cell
// one list slot: holds an element and one stage of the readout lane
// ----------------------------------------------------------------------------
module pli_cell #(
    parameter int INDEX = 0
) (
    input  logic                    aclk,
    input  pli_pkg::cell_cmd_t      cmd,
    input  logic [pli_pkg::VAL_W-1:0] lower_val,
    input  logic [pli_pkg::VAL_W-1:0] upper_val,
    input  logic [pli_pkg::VAL_W-1:0] lane_upper,
    output logic [pli_pkg::VAL_W-1:0] val,
    output logic [pli_pkg::VAL_W-1:0] lane
);
    import pli_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic [VAL_W-1:0] lane_reg;
    logic [VAL_W-1:0] lane_next;

    always_comb begin
        val_next = val_reg;
        if (cmd.ins) begin
            if (MY_IDX > cmd.idx) begin
                val_next = lower_val;
            end else if (MY_IDX == cmd.idx) begin
                val_next = cmd.new_value;
            end
        end else if (cmd.del && (MY_IDX >= cmd.idx)) begin
            val_next = upper_val;
        end
    end

    always_comb begin
        lane_next = lane_reg;
        if (cmd.lane_load) begin
            lane_next = val_reg;
        end else if (cmd.lane_shift) begin
            lane_next = lane_upper;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        lane_reg <= lane_next;
    end

    assign val  = val_reg;
    assign lane = lane_reg;

endmodule

### sv/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// request decode, element count, readout sequencing and output register
// ----------------------------------------------------------------------------
module pli_ctrl #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pli_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pli_pkg::M_DATA_W-1:0] m_tdata,
    output pli_pkg::cell_cmd_t           cmd,
    input  logic [pli_pkg::VAL_W-1:0]    head_val,
    input  logic [pli_pkg::VAL_W-1:0]    lane_head
);
    import pli_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    op_t               in_op;
    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_value;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [IDX_MAX_W-1:0] drain_reg;
    logic [IDX_MAX_W-1:0] drain_next;
    status_t              stat_hold_reg;
    logic                 del_hold_reg;

    logic                 m_valid_reg;
    logic [VAL_W-1:0]     m_removed_reg;
    status_t              m_status_reg;
    logic [ECNT_W-1:0]    m_count_reg;

    logic [CW-1:0]        pos_w;
    logic [CW-1:0]        cnt_w;
    logic [IDX_MAX_W-1:0] idx;
    logic                 accept;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 need_drain;
    logic                 slot_free;
    status_t              stat_now;
    logic                 load_now;
    logic                 load_wait;

    assign in_op    = op_t'(s_tdata[0]);
    assign in_pos   = s_tdata[POS_W:1];
    assign in_value = s_tdata[POS_W+VAL_W:POS_W+1];

    assign pos_w = CW'(in_pos);
    assign cnt_w = CW'(count_reg);
    assign idx   = IDX_MAX_W'(pos_w - CW'(1));

    always_comb begin
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        stat_now = STAT_OK;
        case (in_op)
            OP_INSERT: begin
                if (cnt_w == CW'(CAPACITY)) begin
                    stat_now = STAT_FULL;
                end else if ((pos_w == '0) || (pos_w > cnt_w + CW'(1))) begin
                    stat_now = STAT_BAD;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if ((cnt_w == '0) || (pos_w == '0) || (pos_w > cnt_w)) begin
                    stat_now = STAT_BAD;
                end else begin
                    del_ok = 1'b1;
                end
            end
            default: stat_now = STAT_BAD;
        endcase
    end

    assign accept     = s_tvalid && s_tready;
    assign need_drain = del_ok && (idx != '0);
    assign slot_free  = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (need_drain) begin
                        state_next = ST_DRAIN;
                    end else if (!slot_free) begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_DRAIN: begin
                if (drain_reg == IDX_MAX_W'(1)) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready       = 1'b0;
        load_now       = 1'b0;
        load_wait      = 1'b0;
        cmd.ins        = 1'b0;
        cmd.del        = 1'b0;
        cmd.idx        = idx;
        cmd.new_value  = in_value;
        cmd.lane_load  = 1'b0;
        cmd.lane_shift = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.ins       = accept && ins_ok;
                cmd.del       = accept && del_ok;
                cmd.lane_load = accept && del_ok;
                load_now      = accept && !need_drain && slot_free;
            end
            ST_DRAIN: begin
                cmd.lane_shift = 1'b1;
            end
            ST_WAIT: begin
                load_wait = slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        drain_next = drain_reg;
        if (accept) begin
            drain_next = idx;
        end else if (state_reg == ST_DRAIN) begin
            drain_next = drain_reg - IDX_MAX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_now || load_wait) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        drain_reg <= drain_next;
        if (accept) begin
            stat_hold_reg <= stat_now;
            del_hold_reg  <= del_ok;
        end
        if (load_now) begin
            m_removed_reg <= del_ok ? head_val : '0;
            m_status_reg  <= stat_now;
            m_count_reg   <= ECNT_W'(count_next);
        end else if (load_wait) begin
            m_removed_reg <= del_hold_reg ? lane_head : '0;
            m_status_reg  <= stat_hold_reg;
            m_count_reg   <= ECNT_W'(count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - VAL_W - STAT_W - ECNT_W){1'b0}},
                       m_count_reg, m_status_reg, m_removed_reg};

endmodule

### sv/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// ordered list with insert and delete at a one-based position
// ----------------------------------------------------------------------------
//  port group   dir  tdata bits, lowest first
//  s_*          in   operation[0], position[5:1], new_value[37:6], zero pad
//  m_*          out  removed_value[31:0], status[33:32], element_count[38:34]
//
//  insert, failed request or delete at position 1: loads the output register
//  directly; delete at position p above 1: walks the removed value down the
//  readout lane to the head first, then loads the output register
//  a finished result waits in the output register; a request is still
//  taken then, and the next one only once that result has left
//  reset clears count and handshake state; the list is empty after reset
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pli_pkg::S_DATA_W-1:0] s_tdata,   // operation, position, new_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pli_pkg::M_DATA_W-1:0] m_tdata    // removed_value, status, element_count
);
    import pli_pkg::*;

    cell_cmd_t        cmd;
    logic [VAL_W-1:0] val_w  [CAPACITY];
    logic [VAL_W-1:0] lane_w [CAPACITY];

    pli_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .head_val (val_w[0]),
        .lane_head(lane_w[0])
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VAL_W-1:0] lower;
        logic [VAL_W-1:0] upper;
        logic [VAL_W-1:0] lane_up;

        if (k == 0) begin : g_bot
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = val_w[k-1];
        end

        if (k == CAPACITY - 1) begin : g_top
            assign upper   = '0;
            assign lane_up = '0;
        end else begin : g_mid_hi
            assign upper   = val_w[k+1];
            assign lane_up = lane_w[k+1];
        end

        pli_cell #(
            .INDEX(k)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .lower_val (lower),
            .upper_val (upper),
            .lane_upper(lane_up),
            .val       (val_w[k]),
            .lane      (lane_w[k])
        );
    end

endmodule

### sv/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// port level checks of the positional list block
// ----------------------------------------------------------------------------
module pli_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pli_pkg::M_DATA_W-1:0] m_tdata
);
    import pli_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] != 2'd3))
        else $error("undefined status code");

    a_fail_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != STAT_OK) |-> (m_tdata[31:0] == '0))
        else $error("failed request returned a value");

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (.*);
